// ----- rtl/sbcd_pkg.sv -----
// ----------------------------------------------------------------------------
// sbcd_pkg
// Types and constants shared by the sensor bank change detector modules.
// ----------------------------------------------------------------------------
package sbcd_pkg;

  localparam int BYTE_INDEX_W    = 4;
  localparam int SENSOR_W        = 8;
  localparam int MODULE_W        = 3;
  localparam int SENSOR_NUM_W    = 5;
  localparam int BIT_POS_W       = 3;
  localparam int QUEUE_DEPTH     = 2;
  localparam int MAX_INDEXES     = 1 << BYTE_INDEX_W;
  localparam logic [SENSOR_NUM_W-1:0] SENSORS_PER_BYTE = SENSOR_NUM_W'(SENSOR_W);
  localparam logic [SENSOR_NUM_W-1:0] ODD_BYTE_OFFSET  = SENSOR_NUM_W'(SENSOR_W);

  // One input beat: a sensor byte and its place in the frame.
  typedef struct packed {
    logic [BYTE_INDEX_W-1:0] byte_index;
    logic [SENSOR_W-1:0]     sensor_bits;
  } in_beat_t;

  // One output beat: a single change event.
  typedef struct packed {
    logic [MODULE_W-1:0]     module_index;
    logic [SENSOR_NUM_W-1:0] sensor_number;
    logic                    is_on;
    logic                    last;
  } out_beat_t;

  // A classified byte waiting for the back end.
  typedef struct packed {
    logic [BYTE_INDEX_W-1:0] byte_index;
    logic [SENSOR_W-1:0]     sensor_bits;
    logic [SENSOR_W-1:0]     changed;
  } job_t;

  // Handshake between a queue and its consumer.
  typedef struct packed {
    logic valid;
    job_t job;
  } job_src_t;

endpackage

// ----- rtl/sbcd_front.sv -----
// ----------------------------------------------------------------------------
// sbcd_front
// Accepts sensor bytes, compares them with the stored levels, updates the
// store and hands bytes with changes to the job queue.
// ----------------------------------------------------------------------------
module sbcd_front #(
  parameter int NUM_BYTES = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sbcd_pkg::in_beat_t in_data,
  output logic              push,
  output sbcd_pkg::job_t    push_job,
  input  logic              queue_full
);
  import sbcd_pkg::*;

  // Only indexes that the field can carry need storage.
  localparam int DEPTH = (NUM_BYTES < MAX_INDEXES) ? NUM_BYTES : MAX_INDEXES;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [SENSOR_W-1:0] levels_r   [DEPTH];
  logic [SENSOR_W-1:0] levels_nxt [DEPTH];
  logic                accept;
  logic                in_range;
  logic [IDX_W-1:0]    idx;
  logic [SENSOR_W-1:0] changed;

  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;
  assign in_range = 32'(in_data.byte_index) < NUM_BYTES;
  assign idx      = IDX_W'(in_data.byte_index);
  assign changed  = levels_r[idx] ^ in_data.sensor_bits;

  // A byte goes to the back end only when some sensor changed.
  assign push                = accept && in_range && (changed != '0);
  assign push_job.byte_index = in_data.byte_index;
  assign push_job.sensor_bits = in_data.sensor_bits;
  assign push_job.changed    = changed;

  // The stored levels take the new byte as soon as it is accepted.
  always_comb begin
    levels_nxt = levels_r;
    if (accept && in_range) begin
      levels_nxt[idx] = in_data.sensor_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        levels_r[i] <= '0;
      end
    end else begin
      levels_r <= levels_nxt;
    end
  end

  // A queued job always carries at least one change.
  a_push_has_change: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (push_job.changed != '0))
    else $error("front pushed a byte without changes");

  // Nothing is pushed into a full queue.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    queue_full |-> !push)
    else $error("front pushed into a full queue");

endmodule

// ----- rtl/sbcd_queue.sv -----
// ----------------------------------------------------------------------------
// sbcd_queue
// Short first-in first-out queue of classified bytes between the front and
// the back end.
// ----------------------------------------------------------------------------
module sbcd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sbcd_pkg::job_t      push_job,
  output logic                full,
  input  logic                pop,
  output sbcd_pkg::job_src_t  head
);
  import sbcd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  job_t             slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full       = (cnt_r == FULL_CNT);
  assign head.valid = (cnt_r != '0);
  assign head.job   = slots_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Slot storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  // The fill count never passes the depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("queue fill count out of range");

endmodule

// ----- rtl/sbcd_back.sv -----
// ----------------------------------------------------------------------------
// sbcd_back
// Walks the changed bits of one byte from bit 0 upward and emits one change
// event per cycle into the output register while the output is not stalled.
// ----------------------------------------------------------------------------
module sbcd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  sbcd_pkg::job_src_t  head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output sbcd_pkg::out_beat_t out_data
);
  import sbcd_pkg::*;

  logic [SENSOR_W-1:0]     mask_r, mask_nxt;
  logic [BYTE_INDEX_W-1:0] idx_r;
  logic [SENSOR_W-1:0]     bits_r;
  logic                    out_valid_r, out_valid_nxt;
  out_beat_t               out_r, out_nxt;
  logic                    advance;
  logic                    busy;
  logic [BIT_POS_W-1:0]    pos;
  logic [SENSOR_W-1:0]     mask_after;
  logic                    load;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign advance   = !out_valid_r || !out_stall;
  assign busy      = (mask_r != '0);

  // Lowest changed bit still to report.
  always_comb begin
    pos = '0;
    for (int b = SENSOR_W - 1; b >= 0; b--) begin
      if (mask_r[b]) begin
        pos = BIT_POS_W'(b);
      end
    end
  end

  assign mask_after = mask_r & ~(SENSOR_W'(1) << pos);

  // Take the next byte when idle or when the current one is finishing.
  assign load = head.valid && (!busy || (advance && mask_after == '0));
  assign pop  = load;

  always_comb begin
    mask_nxt      = mask_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (advance) begin
      out_valid_nxt = busy;
      out_nxt.module_index  = idx_r[BYTE_INDEX_W-1:1];
      out_nxt.sensor_number = SENSORS_PER_BYTE - SENSOR_NUM_W'(pos)
                              + (idx_r[0] ? ODD_BYTE_OFFSET : '0);
      out_nxt.is_on         = bits_r[pos];
      out_nxt.last          = (mask_after == '0);
      if (busy) begin
        mask_nxt = mask_after;
      end
    end
    if (load) begin
      mask_nxt = head.job.changed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (load) begin
      idx_r  <= head.job.byte_index;
      bits_r <= head.job.sensor_bits;
    end
  end

  // An event that is not the last one leaves bits still to report.
  a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.last) |-> busy)
    else $error("non-last event with no bits pending");

  // A new byte is never loaded over bits that remain unreported.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && busy) |-> (advance && mask_after == '0))
    else $error("byte loaded over pending bits");

endmodule

// ----- rtl/sensor_bank_change_detector_top.sv -----
// ----------------------------------------------------------------------------
// sensor_bank_change_detector_top
// Sensor bank change detector: per-position level store and change events.
// ----------------------------------------------------------------------------
// Each input beat carries a sensor byte and its position in the frame. The
// byte is compared with the level last seen at that position, and each changed
// bit, from bit 0 upward, leaves as one output beat giving the module, the
// sensor number and the new level, with last set on the final event of the
// byte. Bytes with no change and positions at or above NUM_BYTES produce
// nothing; all stored levels are zero after reset. The front takes one byte
// per cycle while its two-entry job queue has room, and the back end emits one
// event per cycle while the output is not stalled, so a byte with k changed bits
// (one to eight) yields k events and the sustained rate is set by the bit walk.
module sensor_bank_change_detector_top #(
  parameter int NUM_BYTES = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sbcd_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sbcd_pkg::out_beat_t out_data
);
  import sbcd_pkg::*;

  logic     push;
  job_t     push_job;
  logic     queue_full;
  logic     pop;
  job_src_t head;

  // Front: classify and update the stored levels.
  sbcd_front #(
    .NUM_BYTES (NUM_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push       (push),
    .push_job   (push_job),
    .queue_full (queue_full)
  );

  // Job queue between the two halves.
  sbcd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (queue_full),
    .pop      (pop),
    .head     (head)
  );

  // Back end: one event per cycle while the output is not stalled.
  sbcd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
